FILE: hw/rtl/mesh_vertex_normal_accumulate_macros.svh
// assertion helpers for the vertex normal block
`ifndef MESH_VERTEX_NORMAL_ACCUMULATE_MACROS_SVH
`define MESH_VERTEX_NORMAL_ACCUMULATE_MACROS_SVH

// same-cycle implication, checked out of reset
`define MVNA_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MVNA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/mvna_pkg.sv
package mvna_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int IDX_W        = 10;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int ACT_W        = 2;
  localparam int POS_W        = 24;
  localparam int SUM_W        = 24;
  localparam int NRM_W        = 18;
  localparam int VEC_W        = 3 * POS_W;
  localparam int EDGE_W       = POS_W + 1;
  localparam int CR_W         = 52;
  localparam int MAG_W        = 51;
  localparam int Q_W          = 17;
  localparam int NUM_W        = 47;
  localparam int IN_DATA_W    = 112;
  localparam int OUT_DATA_W   = 64;
  localparam int DIV_STEPS    = 17;
  localparam int SQRT_STEPS   = 32;

  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FACE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 24'sh7FFFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = 24'sh800000;

  function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
    return 32'(idx) < MAX_VERTICES;
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                                      input logic signed [NRM_W-1:0] n);
    logic signed [SUM_W:0] t;
    t = (SUM_W+1)'(s) + (SUM_W+1)'(n);
    if (t[SUM_W] != t[SUM_W-1]) begin
      return t[SUM_W] ? SUM_MIN : SUM_MAX;
    end
    return t[SUM_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/mvna_ram.sv
module mvna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/mesh_vertex_normal_accumulate.sv
// Per-vertex smooth normals for a triangle mesh.
// Input stream (s_axis): tuser carries the action. Write vertex (0) stores a
// position and clears that vertex's normal sum together. Add face (1)
// reads three positions, forms the edge cross product, normalizes it and adds
// it, saturating, to the sum of each corner. Read vertex (2) normalizes one
// sum and emits one item on m_axis; null_normal is set for a zero sum or an
// out-of-range index. Products go through one shared 32x32 multiplier and
// square root and division steps through one 64-bit subtractor, under a
// sequencer; tready is low while an item is in work. The normalizing shift
// moves one bit per cycle, by N (0 to 29) places; then come the 32-step
// square root and 17 restoring division steps for each component.
// After reset the normal sum memory is cleared, one entry a cycle, all 1024
// entries, before the first item is taken.
// A finished result sits in an output register; the next item is taken while
// it waits, and a later read holds in its last state until the sink takes it.
module mesh_vertex_normal_accumulate (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
  input  logic [mvna_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // action
  input  logic [mvna_pkg::ACT_W-1:0]          s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // out_vertex, normal_x, normal_y, normal_z
  output logic [mvna_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // null_normal
  output logic [0:0]                          m_axis_tuser_o
);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_FETCH  = 4'd2;
  localparam logic [3:0] ST_CROSS  = 4'd3;
  localparam logic [3:0] ST_RDSUM  = 4'd4;
  localparam logic [3:0] ST_MAG    = 4'd5;
  localparam logic [3:0] ST_NORM   = 4'd6;
  localparam logic [3:0] ST_SQR    = 4'd7;
  localparam logic [3:0] ST_SQRT   = 4'd8;
  localparam logic [3:0] ST_DIV    = 4'd9;
  localparam logic [3:0] ST_ACC_RD = 4'd10;
  localparam logic [3:0] ST_ACC_WR = 4'd11;
  localparam logic [3:0] ST_OUT    = 4'd12;

  localparam int POS_W  = mvna_pkg::POS_W;
  localparam int EDGE_W = mvna_pkg::EDGE_W;
  localparam int CR_W   = mvna_pkg::CR_W;
  localparam int MAG_W  = mvna_pkg::MAG_W;
  localparam int NRM_W  = mvna_pkg::NRM_W;
  localparam int IDX_W  = mvna_pkg::IDX_W;
  localparam int ADDR_W = mvna_pkg::ADDR_W;
  localparam int Q_W    = mvna_pkg::Q_W;
  localparam int NUM_W  = mvna_pkg::NUM_W;

  // input fields
  logic [IDX_W-1:0]        in_vi, in_ca, in_cb, in_cc;
  logic [POS_W-1:0]        in_px, in_py, in_pz;
  logic [mvna_pkg::ACT_W-1:0] in_act;

  assign in_vi  = s_axis_tdata_i[9:0];
  assign in_px  = s_axis_tdata_i[33:10];
  assign in_py  = s_axis_tdata_i[57:34];
  assign in_pz  = s_axis_tdata_i[81:58];
  assign in_ca  = s_axis_tdata_i[91:82];
  assign in_cb  = s_axis_tdata_i[101:92];
  assign in_cc  = s_axis_tdata_i[111:102];
  assign in_act = s_axis_tuser_i;

  // control state
  logic [3:0]        state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [5:0]        step_q, step_d;
  logic [1:0]        comp_q, comp_d;
  logic              m_valid_q, m_valid_d;

  // payload
  logic                    face_q, face_d;
  logic                    null_q, null_d;
  logic [IDX_W-1:0]        vidx_q, vidx_d, ca_q, ca_d, cb_q, cb_d, cc_q, cc_d;
  logic [mvna_pkg::VEC_W-1:0] pa_q, pa_d;
  logic signed [EDGE_W-1:0] e1_q [3];
  logic signed [EDGE_W-1:0] e1_d [3];
  logic signed [EDGE_W-1:0] e2_q [3];
  logic signed [EDGE_W-1:0] e2_d [3];
  logic signed [CR_W-1:0]  c_q [3];
  logic signed [CR_W-1:0]  c_d [3];
  logic [MAG_W-1:0]        m_q [3];
  logic [MAG_W-1:0]        m_d [3];
  logic signed [NRM_W-1:0] n_q [3];
  logic signed [NRM_W-1:0] n_d [3];
  logic signed [63:0]      prod_q;
  logic [63:0]             sq_q, sq_d, res_q, res_d, bit_q, bit_d;
  logic [31:0]             rem_q, rem_d;
  logic [Q_W-1:0]          lo_q, lo_d, quo_q, quo_d;
  logic [mvna_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic                    out_null_q, out_null_d;

  // shared arithmetic
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic [63:0]        sub_a, sub_b;
  logic [64:0]        sub_diff;

  assign mul_p    = mul_a * mul_b;
  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};

  // memories
  logic                       pos_we, sum_we;
  logic [ADDR_W-1:0]          pos_waddr, pos_raddr, sum_waddr, sum_raddr;
  logic [mvna_pkg::VEC_W-1:0] pos_wdata, pos_rdata, sum_wdata, sum_rdata;

  mvna_ram #(.WIDTH(mvna_pkg::VEC_W), .DEPTH(mvna_pkg::MAX_VERTICES)) u_pos_ram (
    .clk_i  (clk_i),
    .we_i   (pos_we),
    .waddr_i(pos_waddr),
    .wdata_i(pos_wdata),
    .raddr_i(pos_raddr),
    .rdata_o(pos_rdata)
  );

  mvna_ram #(.WIDTH(mvna_pkg::VEC_W), .DEPTH(mvna_pkg::MAX_VERTICES)) u_sum_ram (
    .clk_i  (clk_i),
    .we_i   (sum_we),
    .waddr_i(sum_waddr),
    .wdata_i(sum_wdata),
    .raddr_i(sum_raddr),
    .rdata_o(sum_rdata)
  );

  // helpers
  logic signed [EDGE_W-1:0] pdiff [3];
  logic [MAG_W-1:0]         mx;
  logic [IDX_W-1:0]         corner;
  logic [5:0]               pstep;
  logic [1:0]               ck;
  logic [NUM_W-1:0]         num;
  logic [32:0]              dt;
  logic [Q_W-1:0]           qfin;
  logic                     face_ok;

  assign face_ok = mvna_pkg::idx_ok(in_ca) && mvna_pkg::idx_ok(in_cb) &&
                   mvna_pkg::idx_ok(in_cc);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pdiff[k] = EDGE_W'($signed(pos_rdata[k*POS_W +: POS_W])) -
                 EDGE_W'($signed(pa_q[k*POS_W +: POS_W]));
    end
  end

  always_comb begin
    mx = m_q[0];
    if (m_q[1] > mx) mx = m_q[1];
    if (m_q[2] > mx) mx = m_q[2];
  end

  always_comb begin
    case (comp_q)
      2'd0:    corner = ca_q;
      2'd1:    corner = cb_q;
      default: corner = cc_q;
    endcase
  end

  assign pstep = step_q - 6'd1;
  assign ck    = pstep[2:1];
  assign num   = (NUM_W'(m_q[comp_q][29:0]) << 16) + NUM_W'(res_q[31:1]);
  assign dt    = {rem_q, lo_q[Q_W-1]};
  assign qfin  = {quo_q[Q_W-2:0], ~sub_diff[64]};

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_null_q;

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    step_d     = step_q;
    comp_d     = comp_q;
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    face_d     = face_q;
    null_d     = null_q;
    vidx_d     = vidx_q;
    ca_d       = ca_q;
    cb_d       = cb_q;
    cc_d       = cc_q;
    pa_d       = pa_q;
    e1_d       = e1_q;
    e2_d       = e2_q;
    c_d        = c_q;
    m_d        = m_q;
    n_d        = n_q;
    sq_d       = sq_q;
    res_d      = res_q;
    bit_d      = bit_q;
    rem_d      = rem_q;
    lo_d       = lo_q;
    quo_d      = quo_q;
    out_data_d = out_data_q;
    out_null_d = out_null_q;

    pos_we    = 1'b0;
    pos_waddr = in_vi;
    pos_wdata = {in_pz, in_py, in_px};
    pos_raddr = ca_q;
    sum_we    = 1'b0;
    sum_waddr = clr_q;
    sum_wdata = '0;
    sum_raddr = vidx_q;
    mul_a     = '0;
    mul_b     = '0;
    sub_a     = '0;
    sub_b     = '0;

    case (state_q)
      ST_CLEAR: begin
        sum_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == ADDR_W'(mvna_pkg::MAX_VERTICES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          vidx_d = in_vi;
          ca_d   = in_ca;
          cb_d   = in_cb;
          cc_d   = in_cc;
          null_d = 1'b0;
          step_d = '0;
          comp_d = '0;
          case (in_act)
            mvna_pkg::ACT_WRITE: begin
              if (mvna_pkg::idx_ok(in_vi)) begin
                pos_we    = 1'b1;
                sum_we    = 1'b1;
                sum_waddr = in_vi;
              end
            end
            mvna_pkg::ACT_FACE: begin
              face_d = 1'b1;
              if (face_ok) state_d = ST_FETCH;
            end
            mvna_pkg::ACT_READ: begin
              face_d = 1'b0;
              if (mvna_pkg::idx_ok(in_vi)) begin
                state_d = ST_RDSUM;
              end else begin
                null_d  = 1'b1;
                n_d     = '{default: '0};
                state_d = ST_OUT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        // reads issued for a, b, c; data lands in the following cycle
        case (step_q)
          6'd0:    pos_raddr = ca_q;
          6'd1:    pos_raddr = cb_q;
          default: pos_raddr = cc_q;
        endcase
        step_d = step_q + 6'd1;
        if (step_q == 6'd1) pa_d = pos_rdata;
        if (step_q == 6'd2) e1_d = pdiff;
        if (step_q == 6'd3) begin
          e2_d    = pdiff;
          c_d     = '{default: '0};
          step_d  = '0;
          state_d = ST_CROSS;
        end
      end
      ST_CROSS: begin
        case (step_q)
          6'd0:    begin mul_a = 32'(e1_q[1]); mul_b = 32'(e2_q[2]); end
          6'd1:    begin mul_a = 32'(e1_q[2]); mul_b = 32'(e2_q[1]); end
          6'd2:    begin mul_a = 32'(e1_q[2]); mul_b = 32'(e2_q[0]); end
          6'd3:    begin mul_a = 32'(e1_q[0]); mul_b = 32'(e2_q[2]); end
          6'd4:    begin mul_a = 32'(e1_q[0]); mul_b = 32'(e2_q[1]); end
          default: begin mul_a = 32'(e1_q[1]); mul_b = 32'(e2_q[0]); end
        endcase
        // even products add, odd products subtract
        if (step_q != 6'd0) begin
          if (pstep[0]) c_d[ck] = c_q[ck] - prod_q[CR_W-1:0];
          else          c_d[ck] = c_q[ck] + prod_q[CR_W-1:0];
        end
        step_d = step_q + 6'd1;
        if (step_q == 6'd6) begin
          step_d  = '0;
          state_d = ST_MAG;
        end
      end
      ST_RDSUM: begin
        sum_raddr = vidx_q;
        step_d    = step_q + 6'd1;
        if (step_q == 6'd1) begin
          for (int k = 0; k < 3; k++) begin
            c_d[k] = CR_W'($signed(sum_rdata[k*POS_W +: POS_W]));
          end
          step_d  = '0;
          state_d = ST_MAG;
        end
      end
      ST_MAG: begin
        for (int k = 0; k < 3; k++) begin
          m_d[k] = c_q[k][CR_W-1] ? MAG_W'(-c_q[k]) : MAG_W'(c_q[k]);
        end
        state_d = ST_NORM;
      end
      ST_NORM: begin
        // bring the largest magnitude into [2^29, 2^30)
        if (mx == '0) begin
          null_d  = 1'b1;
          n_d     = '{default: '0};
          state_d = face_q ? ST_IDLE : ST_OUT;
        end else if (mx[MAG_W-1:30] != '0) begin
          for (int k = 0; k < 3; k++) m_d[k] = m_q[k] >> 1;
        end else if (!mx[29]) begin
          for (int k = 0; k < 3; k++) m_d[k] = m_q[k] << 1;
        end else begin
          sq_d    = '0;
          step_d  = '0;
          state_d = ST_SQR;
        end
      end
      ST_SQR: begin
        if (step_q != 6'd3) begin
          mul_a = {2'b00, m_q[step_q[1:0]][29:0]};
          mul_b = {2'b00, m_q[step_q[1:0]][29:0]};
        end
        if (step_q != 6'd0) sq_d = sq_q + prod_q;
        step_d = step_q + 6'd1;
        if (step_q == 6'd3) begin
          res_d   = '0;
          bit_d   = 64'd1 << 62;
          step_d  = '0;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        sub_a = sq_q;
        sub_b = res_q + bit_q;
        if (!sub_diff[64]) begin
          sq_d  = sub_diff[63:0];
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d  = bit_q >> 2;
        step_d = step_q + 6'd1;
        if (step_q == 6'(mvna_pkg::SQRT_STEPS - 1)) begin
          step_d  = '0;
          comp_d  = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_q == 6'd0) begin
          rem_d  = 32'(num[NUM_W-1:Q_W]);
          lo_d   = num[Q_W-1:0];
          quo_d  = '0;
          step_d = 6'd1;
        end else begin
          // restoring long division by the length, one quotient bit a cycle
          sub_a  = 64'(dt);
          sub_b  = 64'(res_q[31:0]);
          rem_d  = sub_diff[64] ? dt[31:0] : sub_diff[31:0];
          lo_d   = lo_q << 1;
          quo_d  = qfin;
          step_d = step_q + 6'd1;
          if (step_q == 6'(mvna_pkg::DIV_STEPS)) begin
            n_d[comp_q] = c_q[comp_q][CR_W-1] ? -NRM_W'(qfin) : NRM_W'(qfin);
            step_d      = '0;
            if (comp_q == 2'd2) begin
              comp_d  = '0;
              state_d = face_q ? ST_ACC_RD : ST_OUT;
            end else begin
              comp_d = comp_q + 2'd1;
            end
          end
        end
      end
      ST_ACC_RD: begin
        sum_raddr = corner;
        state_d   = ST_ACC_WR;
      end
      ST_ACC_WR: begin
        sum_we    = 1'b1;
        sum_waddr = corner;
        for (int k = 0; k < 3; k++) begin
          sum_wdata[k*POS_W +: POS_W] =
            mvna_pkg::sat_add($signed(sum_rdata[k*POS_W +: POS_W]), n_q[k]);
        end
        if (comp_q == 2'd2) begin
          comp_d  = '0;
          state_d = ST_IDLE;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = ST_ACC_RD;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d  = 1'b1;
          out_data_d = {n_q[2], n_q[1], n_q[0], vidx_q};
          out_null_d = null_q;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      step_q    <= '0;
      comp_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      step_q    <= step_d;
      comp_q    <= comp_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    face_q     <= face_d;
    null_q     <= null_d;
    vidx_q     <= vidx_d;
    ca_q       <= ca_d;
    cb_q       <= cb_d;
    cc_q       <= cc_d;
    pa_q       <= pa_d;
    e1_q       <= e1_d;
    e2_q       <= e2_d;
    c_q        <= c_d;
    m_q        <= m_d;
    n_q        <= n_d;
    prod_q     <= mul_p;
    sq_q       <= sq_d;
    res_q      <= res_d;
    bit_q      <= bit_d;
    rem_q      <= rem_d;
    lo_q       <= lo_d;
    quo_q      <= quo_d;
    out_data_q <= out_data_d;
    out_null_q <= out_null_d;
  end

`include "mesh_vertex_normal_accumulate_macros.svh"

  `MVNA_ASSERT(a_null_zero, m_axis_tvalid_o && m_axis_tuser_o[0], m_axis_tdata_o[63:10] == '0, "null normal with nonzero components")
  `MVNA_ASSERT(a_sqr_window, state_q == ST_SQR, mx[MAG_W-1:30] == '0 && mx[29], "normalized magnitude out of window")
  `MVNA_ASSERT(a_len_range, state_q == ST_DIV, res_q[63:32] == '0 && res_q[31:0] != '0, "vector length out of range")
  `MVNA_ASSERT_NEXT(a_face_fetch, s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == mvna_pkg::ACT_FACE && face_ok, state_q == ST_FETCH, "face item did not start fetch")

endmodule
